// ===== sv/assert_macros.svh =====
// Assertion helpers for the disk request scheduler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant that holds at every clock edge outside reset.
`define DRS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Implication checked at a clock edge outside reset.
`define DRS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/drs_pkg.sv =====
package drs_pkg;

    localparam int CYL_W       = 10;
    localparam int SEEK_W      = 16;
    localparam int POLICY_W    = 3;
    localparam int CFG_W       = 10;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 32;

    localparam logic [POLICY_W-1:0] RST_POLICY = 3'd0;
    localparam logic [CYL_W-1:0]    RST_START  = 10'd53;
    localparam logic [CYL_W-1:0]    RST_MAX    = 10'd199;
    localparam logic [SEEK_W-1:0]   SEEK_SAT   = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX    = 2'd2;

    localparam logic [POLICY_W-1:0] POL_FCFS  = 3'd0;
    localparam logic [POLICY_W-1:0] POL_SSTF  = 3'd1;
    localparam logic [POLICY_W-1:0] POL_SCAN  = 3'd2;
    localparam logic [POLICY_W-1:0] POL_CSCAN = 3'd3;
    localparam logic [POLICY_W-1:0] POL_LOOK  = 3'd4;
    localparam logic [POLICY_W-1:0] POL_CLOOK = 3'd5;

    // search criterion broadcast to every cell
    typedef enum logic [2:0] {
        M_FIRST  = 3'd0,   // earliest loaded
        M_NEAR   = 3'd1,   // nearest to head
        M_MAX_LO = 3'd2,   // largest at or below start
        M_MIN_HI = 3'd3,   // smallest above start
        M_MAX_HI = 3'd4,
        M_MIN_LO = 3'd5
    } mode_t;

    typedef struct packed {
        mode_t            mode;
        logic [CYL_W-1:0] start;
        logic [CYL_W-1:0] head;
    } cell_ctl_t;

    typedef struct packed {
        logic             found;
        logic [CYL_W-1:0] key;
        logic [CYL_W-1:0] value;
    } cand_t;

endpackage

// ===== sv/drs_if.sv =====
interface drs_req_if;
    logic                      valid;
    logic                      ready;
    logic [drs_pkg::CYL_W-1:0] cylinder;
    logic                      last;

    modport source (output valid, output cylinder, output last, input ready);
    modport sink   (input valid, input cylinder, input last, output ready);
endinterface

interface drs_visit_if;
    logic                       valid;
    logic                       ready;
    logic [drs_pkg::CYL_W-1:0]  position;
    logic                       is_edge;
    logic [drs_pkg::SEEK_W-1:0] total_seek;
    logic                       dropped;
    logic                       end_of_run;

    modport source (output valid, output position, output is_edge, output total_seek,
                    output dropped, output end_of_run, input ready);
    modport sink   (input valid, input position, input is_edge, input total_seek,
                    input dropped, input end_of_run, output ready);
endinterface

// ===== sv/drs_cell.sv =====
module drs_cell #(
    parameter int IDX_W = 5,
    parameter int IDX   = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load_en,
    input  logic [drs_pkg::CYL_W-1:0] load_value,
    input  logic                      clear,
    input  logic                      mark_en,
    input  logic                      active,
    input  drs_pkg::cell_ctl_t        ctl,
    input  drs_pkg::cand_t            cand_in,
    input  logic [IDX_W-1:0]          idx_in,
    output drs_pkg::cand_t            cand_out,
    output logic [IDX_W-1:0]          idx_out
);

    logic [drs_pkg::CYL_W-1:0] value_reg;
    logic                      served_reg;
    logic                      found_reg;
    logic [drs_pkg::CYL_W-1:0] key_reg;
    logic [drs_pkg::CYL_W-1:0] cval_reg;
    logic [IDX_W-1:0]          idx_reg;

    logic                      side_lo;
    logic                      elig;
    logic [drs_pkg::CYL_W-1:0] key;
    logic                      take;

    always_comb
    begin
        side_lo = (value_reg <= ctl.start);
        elig    = 1'b0;
        key     = '0;
        unique case (ctl.mode)
            drs_pkg::M_FIRST:
            begin
                elig = 1'b1;
            end
            drs_pkg::M_NEAR:
            begin
                elig = 1'b1;
                key  = (value_reg > ctl.head) ? (value_reg - ctl.head)
                                              : (ctl.head - value_reg);
            end
            drs_pkg::M_MAX_LO:
            begin
                elig = side_lo;
                key  = ~value_reg;
            end
            drs_pkg::M_MIN_HI:
            begin
                elig = !side_lo;
                key  = value_reg;
            end
            drs_pkg::M_MAX_HI:
            begin
                elig = !side_lo;
                key  = ~value_reg;
            end
            drs_pkg::M_MIN_LO:
            begin
                elig = side_lo;
                key  = value_reg;
            end
            default:
            begin
                elig = 1'b0;
            end
        endcase
        // strict compare keeps the earlier-loaded entry on a tie
        take = active && !served_reg && elig && (!cand_in.found || key < cand_in.key);
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            value_reg <= load_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            served_reg <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            if (clear || load_en)
            begin
                served_reg <= 1'b0;
            end
            else if (mark_en)
            begin
                served_reg <= 1'b1;
            end
            found_reg <= take ? 1'b1 : cand_in.found;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= take ? key : cand_in.key;
        cval_reg <= take ? value_reg : cand_in.value;
        idx_reg  <= take ? IDX_W'(IDX) : idx_in;
    end

    assign cand_out = {found_reg, key_reg, cval_reg};
    assign idx_out  = idx_reg;

endmodule

// ===== sv/disk_request_scheduler.sv =====
// Load: one request beat per cycle; ready stays high while a batch is loading.
// Schedule: each request visit is a search through the cell chain followed by an
//   output state that holds until the visit is taken; edge visits need no search;
//   sweep policies add two probe searches up front and one empty search at the turn.
//   Input is held off meanwhile.
// Reset (async, active low): batch empty, policy FCFS, start 53, max cylinder 199.
`include "assert_macros.svh"

module disk_request_scheduler #(
    parameter int QUEUE_DEPTH = drs_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [drs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [drs_pkg::CFG_W-1:0]     cfg_wdata,
    drs_req_if.sink                       req,
    drs_visit_if.source                   visit
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int WAIT_W = $clog2(QUEUE_DEPTH + 1);

    // Sequencer: for sweep policies, probes find the nearest entry on each side of the
    // start, the first segment serves toward the nearer side, optional edge visits
    // follow, then the second segment serves the rest.
    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PROBE_LO = 8'b0000_0010,
        S_PROBE_HI = 8'b0000_0100,
        S_SEG1     = 8'b0000_1000,
        S_EDGE_A   = 8'b0001_0000,
        S_EDGE_B   = 8'b0010_0000,
        S_SEG2     = 8'b0100_0000,
        S_EMIT     = 8'b1000_0000
    } state_t;

    // configuration
    logic [drs_pkg::POLICY_W-1:0] policy_reg;
    logic [drs_pkg::CYL_W-1:0]    start_reg;
    logic [drs_pkg::CYL_W-1:0]    max_reg;

    // control
    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    drs_pkg::mode_t      mode_reg, mode_next;
    logic                left_reg, left_next;
    logic                lo_found_reg, lo_found_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    served_cnt_reg, served_cnt_next;
    logic                overflow_reg, overflow_next;
    logic [WAIT_W-1:0]   wait_reg, wait_next;

    // datapath
    logic [drs_pkg::CYL_W-1:0]  lo_val_reg, lo_val_next;
    logic [drs_pkg::CYL_W-1:0]  head_reg, head_next;
    logic [drs_pkg::SEEK_W-1:0] total_reg, total_next;
    logic [drs_pkg::CYL_W-1:0]  pos_reg, pos_next;
    logic                       edge_reg, edge_next;
    logic                       end_reg, end_next;

    // cell chain
    drs_pkg::cand_t            cand [QUEUE_DEPTH+1];
    logic [IDX_W-1:0]          cidx [QUEUE_DEPTH+1];
    drs_pkg::cell_ctl_t        ctl;
    logic                      load_go;
    logic [drs_pkg::CYL_W-1:0] load_value;
    logic                      clear_go;
    logic                      mark_go;
    drs_pkg::cand_t            res;
    logic [IDX_W-1:0]          res_idx;

    // visit helper signals
    logic                       vis_go;
    logic [drs_pkg::CYL_W-1:0]  vis_pos;
    logic                       vis_edge;
    logic [drs_pkg::CYL_W-1:0]  vis_dist;
    logic [drs_pkg::SEEK_W:0]   vis_sum;

    logic                       accept;
    logic                       search_done;
    logic                       wrap;
    logic [CNT_W-1:0]           served_inc;
    logic                       hi_left;

    assign accept      = req.valid && req.ready;
    assign search_done = (wait_reg == WAIT_W'(QUEUE_DEPTH));
    assign res         = cand[QUEUE_DEPTH];
    assign res_idx     = cidx[QUEUE_DEPTH];
    assign served_inc  = served_cnt_reg + 1'b1;
    assign wrap        = (policy_reg == drs_pkg::POL_CSCAN) ||
                         (policy_reg == drs_pkg::POL_CLOOK);
    assign load_value  = (req.cylinder > max_reg) ? max_reg : req.cylinder;
    assign load_go     = accept && (count_reg < CNT_W'(QUEUE_DEPTH));

    assign ctl.mode  = mode_reg;
    assign ctl.start = start_reg;
    assign ctl.head  = head_reg;

    assign cand[0] = '0;
    assign cidx[0] = '0;

    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++)
    begin : g_cell
        drs_cell #(
            .IDX_W (IDX_W),
            .IDX   (gi)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .load_en    (load_go && (count_reg == CNT_W'(gi))),
            .load_value (load_value),
            .clear      (clear_go),
            .mark_en    (mark_go && (res_idx == IDX_W'(gi))),
            .active     (count_reg > CNT_W'(gi)),
            .ctl        (ctl),
            .cand_in    (cand[gi]),
            .idx_in     (cidx[gi]),
            .cand_out   (cand[gi+1]),
            .idx_out    (cidx[gi+1])
        );
    end

    // distance and saturating running total for the visit being issued
    always_comb
    begin
        vis_dist = (vis_pos > head_reg) ? (vis_pos - head_reg) : (head_reg - vis_pos);
        vis_sum  = {1'b0, total_reg} + (drs_pkg::SEEK_W + 1)'(vis_dist);
    end

    always_comb
    begin
        state_next      = state_reg;
        ret_next        = ret_reg;
        mode_next       = mode_reg;
        left_next       = left_reg;
        lo_found_next   = lo_found_reg;
        lo_val_next     = lo_val_reg;
        count_next      = count_reg;
        served_cnt_next = served_cnt_reg;
        overflow_next   = overflow_reg;
        wait_next       = wait_reg;
        head_next       = head_reg;
        total_next      = total_reg;
        pos_next        = pos_reg;
        edge_next       = edge_reg;
        end_next        = end_reg;
        clear_go        = 1'b0;
        mark_go         = 1'b0;
        vis_go          = 1'b0;
        vis_pos         = '0;
        vis_edge        = 1'b0;
        hi_left         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (load_go)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (req.last)
                    begin
                        head_next       = start_reg;
                        total_next      = '0;
                        served_cnt_next = '0;
                        wait_next       = '0;
                        if (policy_reg == drs_pkg::POL_SSTF)
                        begin
                            mode_next  = drs_pkg::M_NEAR;
                            state_next = S_SEG1;
                        end
                        else if (policy_reg >= drs_pkg::POL_SCAN &&
                                 policy_reg <= drs_pkg::POL_CLOOK)
                        begin
                            mode_next  = drs_pkg::M_MAX_LO;
                            state_next = S_PROBE_LO;
                        end
                        else
                        begin
                            mode_next  = drs_pkg::M_FIRST;
                            state_next = S_SEG1;
                        end
                    end
                end
            end
            S_PROBE_LO:
            begin
                wait_next = wait_reg + 1'b1;
                if (search_done)
                begin
                    lo_found_next = res.found;
                    lo_val_next   = res.value;
                    mode_next     = drs_pkg::M_MIN_HI;
                    wait_next     = '0;
                    state_next    = S_PROBE_HI;
                end
            end
            S_PROBE_HI:
            begin
                wait_next = wait_reg + 1'b1;
                if (search_done)
                begin
                    // nearer side first, tie goes low
                    hi_left    = !res.found ||
                                 (lo_found_reg &&
                                  ((start_reg - lo_val_reg) <= (res.value - start_reg)));
                    left_next  = hi_left;
                    mode_next  = hi_left ? drs_pkg::M_MAX_LO : drs_pkg::M_MIN_HI;
                    wait_next  = '0;
                    state_next = S_SEG1;
                end
            end
            S_SEG1, S_SEG2:
            begin
                wait_next = wait_reg + 1'b1;
                if (search_done)
                begin
                    if (res.found)
                    begin
                        mark_go         = 1'b1;
                        served_cnt_next = served_inc;
                        vis_go          = 1'b1;
                        vis_pos         = res.value;
                        end_next        = (served_inc == count_reg);
                        ret_next        = state_reg;
                    end
                    else if (state_reg == S_SEG2)
                    begin
                        // nothing left; not reached with a consistent batch
                        clear_go        = 1'b1;
                        count_next      = '0;
                        served_cnt_next = '0;
                        overflow_next   = 1'b0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        if (left_reg)
                        begin
                            mode_next = wrap ? drs_pkg::M_MAX_HI : drs_pkg::M_MIN_HI;
                        end
                        else
                        begin
                            mode_next = wrap ? drs_pkg::M_MIN_LO : drs_pkg::M_MAX_LO;
                        end
                        wait_next = '0;
                        if (policy_reg == drs_pkg::POL_SCAN ||
                            policy_reg == drs_pkg::POL_CSCAN)
                        begin
                            state_next = S_EDGE_A;
                        end
                        else
                        begin
                            state_next = S_SEG2;
                        end
                    end
                end
            end
            S_EDGE_A:
            begin
                vis_go   = 1'b1;
                vis_edge = 1'b1;
                vis_pos  = left_reg ? '0 : max_reg;
                end_next = 1'b0;
                ret_next = (policy_reg == drs_pkg::POL_CSCAN) ? S_EDGE_B : S_SEG2;
            end
            S_EDGE_B:
            begin
                vis_go   = 1'b1;
                vis_edge = 1'b1;
                vis_pos  = left_reg ? max_reg : '0;
                end_next = 1'b0;
                ret_next = S_SEG2;
            end
            S_EMIT:
            begin
                if (visit.ready)
                begin
                    wait_next = '0;
                    if (end_reg)
                    begin
                        clear_go        = 1'b1;
                        count_next      = '0;
                        served_cnt_next = '0;
                        overflow_next   = 1'b0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = ret_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (vis_go)
        begin
            pos_next   = vis_pos;
            edge_next  = vis_edge;
            head_next  = vis_pos;
            total_next = vis_sum[drs_pkg::SEEK_W] ? drs_pkg::SEEK_SAT
                                                  : vis_sum[drs_pkg::SEEK_W-1:0];
            state_next = S_EMIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= drs_pkg::RST_POLICY;
            start_reg  <= drs_pkg::RST_START;
            max_reg    <= drs_pkg::RST_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                drs_pkg::REG_POLICY: policy_reg <= cfg_wdata[drs_pkg::POLICY_W-1:0];
                drs_pkg::REG_START:  start_reg  <= cfg_wdata[drs_pkg::CYL_W-1:0];
                drs_pkg::REG_MAX:    max_reg    <= cfg_wdata[drs_pkg::CYL_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ret_reg        <= S_IDLE;
            mode_reg       <= drs_pkg::M_FIRST;
            left_reg       <= 1'b0;
            lo_found_reg   <= 1'b0;
            count_reg      <= '0;
            served_cnt_reg <= '0;
            overflow_reg   <= 1'b0;
            wait_reg       <= '0;
            head_reg       <= drs_pkg::RST_START;
            total_reg      <= '0;
            end_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ret_reg        <= ret_next;
            mode_reg       <= mode_next;
            left_reg       <= left_next;
            lo_found_reg   <= lo_found_next;
            count_reg      <= count_next;
            served_cnt_reg <= served_cnt_next;
            overflow_reg   <= overflow_next;
            wait_reg       <= wait_next;
            head_reg       <= head_next;
            total_reg      <= total_next;
            end_reg        <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_val_reg <= lo_val_next;
        pos_reg    <= pos_next;
        edge_reg   <= edge_next;
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign visit.valid      = (state_reg == S_EMIT);
    assign visit.position   = pos_reg;
    assign visit.is_edge    = edge_reg;
    assign visit.total_seek = total_reg;
    assign visit.dropped    = overflow_reg;
    assign visit.end_of_run = end_reg;

    // ---------------------------------------------------------------- checks
    `DRS_ASSERT_ALWAYS(a_served_le_count, served_cnt_reg <= count_reg,
        "more requests served than loaded")
    `DRS_ASSERT_IMPL(a_edge_not_final, visit.valid && visit.is_edge, !visit.end_of_run,
        "edge visit marked as final")
    `DRS_ASSERT_NEXT(a_final_clears, visit.valid && visit.ready && visit.end_of_run,
        count_reg == '0 && !overflow_reg && req.ready,
        "batch not cleared after final visit")
    `DRS_ASSERT_IMPL(a_final_all_served, visit.valid && visit.end_of_run,
        served_cnt_reg == count_reg,
        "final visit with requests still unserved")

endmodule
